FILE: hw/rtl/vrfh_pkg.sv
// Shared types and constants for the voxel ray first-hit core.
package vrfh_pkg;

   // beat layout widths
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 24;

   // action codes
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_RAY   = 1'b1;

   // walk cell coordinate width (start voxel plus up to 512 steps)
   localparam int CELL_W = 12;

   // indexes of the six cross products num_a * den_b
   localparam logic [2:0] P_XY = 3'd0;
   localparam logic [2:0] P_YX = 3'd1;
   localparam logic [2:0] P_XZ = 3'd2;
   localparam logic [2:0] P_ZX = 3'd3;
   localparam logic [2:0] P_YZ = 3'd4;
   localparam logic [2:0] P_ZY = 3'd5;
   localparam int NUM_PROD = 6;

   // per-axis walk setup
   typedef struct packed {
      logic signed [7:0] vox;
      logic signed [7:0] last;
      logic              dir_pos;
      logic [15:0]       den;
      logic [8:0]        num;
   } axis_setup_type;

   // one classified item between front and back
   typedef struct packed {
      logic              action;
      axis_setup_type    ax;
      axis_setup_type    ay;
      axis_setup_type    az;
      logic signed [4:0] wcell_x;
      logic signed [4:0] wcell_y;
      logic signed [4:0] wcell_z;
      logic              wocc;
      logic              wr_ok;
   } item_type;

endpackage

FILE: hw/rtl/voxel_ray_first_hit_core.sv
// Flow: a write beat updates the bitmap when it is popped from the queue, then gives its result beat;
// a ray beat is popped from the queue, computes its six setup products on one shared multiplier,
// then walks voxel steps (bitmap read, then test) until a hit or grid exit, or until the end
// check sees the end voxel or the step limit, and then gives its result beat.
// Throughput: one beat at a time in the walker; a two-entry queue buffers requests.
// Reset: synchronous; afterwards a clear sweep over all 8*HX*HY*HZ bitmap cells, each axis
// rounded up to a power of two (32768 cells by default), runs while req_tready stays low.
module voxel_ray_first_hit_core #(
   parameter int GRID_HALF_X = 16,
   parameter int GRID_HALF_Y = 16,
   parameter int GRID_HALF_Z = 16,
   parameter int MAX_STEPS   = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // start_x, start_y, start_z, end_x, end_y, end_z, cell_x, cell_y, cell_z, cell_occupied
   input  logic [vrfh_pkg::REQ_DATA_W-1:0] req_tdata,
   // action
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // hit_found, hit_x, hit_y, hit_z, step_limit_hit, zero fill
   output logic [vrfh_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import vrfh_pkg::*;

   logic     clearing, q_push, q_ready, q_valid, q_pop;
   item_type push_item, pop_item;

   vrfh_front #(
      .GRID_HALF_X(GRID_HALF_X), .GRID_HALF_Y(GRID_HALF_Y), .GRID_HALF_Z(GRID_HALF_Z)
   ) u_front (
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .clearing(clearing), .q_ready(q_ready),
      .q_push(q_push), .q_item(push_item)
   );

   vrfh_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_item(push_item),
      .push_ready(q_ready), .pop(q_pop), .pop_valid(q_valid), .pop_item(pop_item)
   );

   vrfh_back #(
      .GRID_HALF_X(GRID_HALF_X), .GRID_HALF_Y(GRID_HALF_Y), .GRID_HALF_Z(GRID_HALF_Z),
      .MAX_STEPS(MAX_STEPS)
   ) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_item(pop_item), .q_pop(q_pop),
      .clearing(clearing), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   // no request beat taken during the clear sweep
   a_no_req_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_tready) else $error("request accepted during clear");

   // a hit and a step-limit stop never come together
   a_hit_xor_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[16])) else $error("hit with limit");

   // reset release always starts with the clear sweep
   a_reset_clear: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> clearing) else $error("no clear after reset");

   // no result beat while clearing
   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_tvalid) else $error("result during clear");

endmodule

FILE: hw/rtl/vrfh_front.sv
// Front end: accepts request beats and computes the per-axis walk setup.
module vrfh_front #(
   parameter int GRID_HALF_X = 16,
   parameter int GRID_HALF_Y = 16,
   parameter int GRID_HALF_Z = 16
) (
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [vrfh_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   input  logic                            clearing,
   input  logic                            q_ready,
   output logic                            q_push,
   output vrfh_pkg::item_type              q_item
);
   import vrfh_pkg::*;

   function automatic axis_setup_type setup_axis(logic signed [15:0] s, logic signed [15:0] e);
      axis_setup_type    a;
      logic signed [16:0] d;
      d = {e[15], e} - {s[15], s};
      a.vox     = s[15:8];
      a.last    = e[15:8];
      a.dir_pos = ~d[16];
      a.den     = d[16] ? 16'(-d) : d[15:0];
      // distance to the first boundary in the step direction
      a.num     = d[16] ? {1'b0, s[7:0]} : (9'd256 - {1'b0, s[7:0]});
      return a;
   endfunction

   function automatic logic in_half(logic signed [4:0] c, int half);
      logic signed [7:0] w;
      w = {{3{c[4]}}, c};
      return (w >= -8'(half)) && (w < 8'(half));
   endfunction

   // handshake: no beats while the bitmap clear runs
   assign req_tready = q_ready & ~clearing;
   assign q_push     = req_tvalid & req_tready;

   // decode and classify
   always_comb begin
      q_item.action  = req_tuser;
      q_item.ax      = setup_axis(req_tdata[15:0],  req_tdata[63:48]);
      q_item.ay      = setup_axis(req_tdata[31:16], req_tdata[79:64]);
      q_item.az      = setup_axis(req_tdata[47:32], req_tdata[95:80]);
      q_item.wcell_x = req_tdata[100:96];
      q_item.wcell_y = req_tdata[105:101];
      q_item.wcell_z = req_tdata[110:106];
      q_item.wocc    = req_tdata[111];
      q_item.wr_ok   = in_half(req_tdata[100:96], GRID_HALF_X) &&
                       in_half(req_tdata[105:101], GRID_HALF_Y) &&
                       in_half(req_tdata[110:106], GRID_HALF_Z);
   end

endmodule

FILE: hw/rtl/vrfh_queue.sv
// Two-entry queue between front and back.
module vrfh_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  vrfh_pkg::item_type push_item,
   output logic               push_ready,
   input  logic               pop,
   output logic               pop_valid,
   output vrfh_pkg::item_type pop_item
);
   import vrfh_pkg::*;

   item_type   ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = ent_ff[rd_ptr_ff];
   assign do_push    = push & push_ready;
   assign do_pop     = pop & pop_valid;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: hw/rtl/vrfh_back.sv
// Back end: occupancy bitmap, clear sweep, setup products and voxel walk.
module vrfh_back #(
   parameter int GRID_HALF_X = 16,
   parameter int GRID_HALF_Y = 16,
   parameter int GRID_HALF_Z = 16,
   parameter int MAX_STEPS   = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  vrfh_pkg::item_type              q_item,
   output logic                            q_pop,
   output logic                            clearing,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [vrfh_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import vrfh_pkg::*;

   localparam int XB     = $clog2(2 * GRID_HALF_X);
   localparam int YB     = $clog2(2 * GRID_HALF_Y);
   localparam int ZB     = $clog2(2 * GRID_HALF_Z);
   localparam int ADDR_W = XB + YB + ZB;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam int NUM_W  = $clog2(256 * (MAX_STEPS + 1) + 1);
   localparam int PROD_W = NUM_W + 16;
   localparam int STEP_W = $clog2(MAX_STEPS + 1);
   localparam logic [ADDR_W-1:0] ORIGIN = {XB'(GRID_HALF_X), YB'(GRID_HALF_Y),
                                           ZB'(GRID_HALF_Z)};

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_MUL   = 6'b000100,
      ST_STEP  = 6'b001000,
      ST_TEST  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   logic mem [DEPTH];

   state_type                 state_ff, state_in;
   logic [ADDR_W-1:0]         clr_ff, clr_in;
   logic signed [CELL_W-1:0]  cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic signed [7:0]         lx_ff, lx_in, ly_ff, ly_in, lz_ff, lz_in;
   logic                      px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic [15:0]               dx_ff, dx_in, dy_ff, dy_in, dz_ff, dz_in;
   logic [8:0]                nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;
   logic [PROD_W-1:0]         prod_ff [NUM_PROD];
   logic [PROD_W-1:0]         prod_in [NUM_PROD];
   logic [2:0]                mcnt_ff, mcnt_in;
   logic [STEP_W-1:0]         steps_ff, steps_in;
   logic                      rd_ff;
   logic                      found_ff, found_in, limit_ff, limit_in;
   logic                      rv_ff, rv_in;
   logic [RSP_DATA_W-1:0]     rd_data_ff, rd_data_in;

   logic                      we, wdata;
   logic [ADDR_W-1:0]         waddr, raddr;
   logic [8:0]                mul_a;
   logic [15:0]               mul_b;
   logic [24:0]               mul_p;
   logic                      e_xy, e_xz, e_yz, at_end, ingrid;
   logic signed [CELL_W-1:0]  ncx, ncy, ncz;

   function automatic logic earlier(logic [15:0] den_a, logic [15:0] den_b,
                                    logic [PROD_W-1:0] p_ab, logic [PROD_W-1:0] p_ba);
      return (den_a != 16'd0) && ((den_b == 16'd0) || (p_ab < p_ba));
   endfunction

   function automatic logic signed [CELL_W-1:0] stepped(logic signed [CELL_W-1:0] c,
                                                         logic pos);
      return pos ? c + CELL_W'(1) : c - CELL_W'(1);
   endfunction

   function automatic logic in_half(logic signed [CELL_W-1:0] c, int half);
      return (c >= -CELL_W'(half)) && (c < CELL_W'(half));
   endfunction

   assign clearing   = (state_ff == ST_CLEAR);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_data_ff;

   // axis choice: ties go to z, then y
   assign e_xy   = earlier(dx_ff, dy_ff, prod_ff[P_XY], prod_ff[P_YX]);
   assign e_xz   = earlier(dx_ff, dz_ff, prod_ff[P_XZ], prod_ff[P_ZX]);
   assign e_yz   = earlier(dy_ff, dz_ff, prod_ff[P_YZ], prod_ff[P_ZY]);
   assign at_end = (cx_ff == CELL_W'(lx_ff)) && (cy_ff == CELL_W'(ly_ff)) &&
                   (cz_ff == CELL_W'(lz_ff));
   assign ingrid = in_half(cx_ff, GRID_HALF_X) && in_half(cy_ff, GRID_HALF_Y) &&
                   in_half(cz_ff, GRID_HALF_Z);

   // shared setup multiplier
   always_comb begin
      unique case (mcnt_ff)
         P_XY:    begin mul_a = nx_ff; mul_b = dy_ff; end
         P_YX:    begin mul_a = ny_ff; mul_b = dx_ff; end
         P_XZ:    begin mul_a = nx_ff; mul_b = dz_ff; end
         P_ZX:    begin mul_a = nz_ff; mul_b = dx_ff; end
         P_YZ:    begin mul_a = ny_ff; mul_b = dz_ff; end
         default: begin mul_a = nz_ff; mul_b = dy_ff; end
      endcase
      mul_p = mul_a * mul_b;
   end

   // control and datapath next state
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff;
      lx_in = lx_ff; ly_in = ly_ff; lz_in = lz_ff;
      px_in = px_ff; py_in = py_ff; pz_in = pz_ff;
      dx_in = dx_ff; dy_in = dy_ff; dz_in = dz_ff;
      nx_in = nx_ff; ny_in = ny_ff; nz_in = nz_ff;
      for (int i = 0; i < NUM_PROD; i++) prod_in[i] = prod_ff[i];
      mcnt_in    = mcnt_ff;
      steps_in   = steps_ff;
      found_in   = found_ff;
      limit_in   = limit_ff;
      rv_in      = rv_ff & ~rsp_tready;
      rd_data_in = rd_data_ff;
      q_pop      = 1'b0;
      we         = 1'b0;
      wdata      = 1'b0;
      waddr      = clr_ff;
      ncx = cx_ff; ncy = cy_ff; ncz = cz_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            // sweep the bitmap, origin cell set
            we     = 1'b1;
            wdata  = (clr_ff == ORIGIN);
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            found_in = 1'b0;
            limit_in = 1'b0;
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.action == ACT_WRITE) begin
                  we       = q_item.wr_ok;
                  wdata    = q_item.wocc;
                  waddr    = {XB'(CELL_W'(q_item.wcell_x) + CELL_W'(GRID_HALF_X)),
                              YB'(CELL_W'(q_item.wcell_y) + CELL_W'(GRID_HALF_Y)),
                              ZB'(CELL_W'(q_item.wcell_z) + CELL_W'(GRID_HALF_Z))};
                  state_in = ST_DONE;
               end else begin
                  cx_in = CELL_W'(q_item.ax.vox);
                  cy_in = CELL_W'(q_item.ay.vox);
                  cz_in = CELL_W'(q_item.az.vox);
                  lx_in = q_item.ax.last; ly_in = q_item.ay.last; lz_in = q_item.az.last;
                  px_in = q_item.ax.dir_pos; py_in = q_item.ay.dir_pos;
                  pz_in = q_item.az.dir_pos;
                  dx_in = q_item.ax.den; dy_in = q_item.ay.den; dz_in = q_item.az.den;
                  nx_in = q_item.ax.num; ny_in = q_item.ay.num; nz_in = q_item.az.num;
                  mcnt_in  = 3'd0;
                  steps_in = '0;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in[mcnt_ff] = PROD_W'(mul_p);
            mcnt_in = mcnt_ff + 3'd1;
            if (mcnt_ff == 3'(NUM_PROD - 1)) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            priority if (at_end) begin
               state_in = ST_DONE;
            end else if (steps_ff >= STEP_W'(MAX_STEPS)) begin
               limit_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               if (e_xy && e_xz) begin
                  ncx = stepped(cx_ff, px_ff);
                  prod_in[P_XY] = prod_ff[P_XY] + PROD_W'({dy_ff, 8'd0});
                  prod_in[P_XZ] = prod_ff[P_XZ] + PROD_W'({dz_ff, 8'd0});
               end else if (!e_xy && e_yz) begin
                  ncy = stepped(cy_ff, py_ff);
                  prod_in[P_YX] = prod_ff[P_YX] + PROD_W'({dx_ff, 8'd0});
                  prod_in[P_YZ] = prod_ff[P_YZ] + PROD_W'({dz_ff, 8'd0});
               end else begin
                  ncz = stepped(cz_ff, pz_ff);
                  prod_in[P_ZX] = prod_ff[P_ZX] + PROD_W'({dx_ff, 8'd0});
                  prod_in[P_ZY] = prod_ff[P_ZY] + PROD_W'({dy_ff, 8'd0});
               end
               cx_in = ncx; cy_in = ncy; cz_in = ncz;
               steps_in = steps_ff + STEP_W'(1);
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            priority if (!ingrid) begin
               state_in = ST_DONE;
            end else if (rd_ff) begin
               found_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_DONE: begin
            // result beat: found, x, y, z, limit
            if (!rv_ff || rsp_tready) begin
               rv_in      = 1'b1;
               rd_data_in = {7'd0, limit_ff,
                             found_ff ? cz_ff[4:0] : 5'd0,
                             found_ff ? cy_ff[4:0] : 5'd0,
                             found_ff ? cx_ff[4:0] : 5'd0, found_ff};
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      raddr = {XB'(ncx + CELL_W'(GRID_HALF_X)), YB'(ncy + CELL_W'(GRID_HALF_Y)),
               ZB'(ncz + CELL_W'(GRID_HALF_Z))};
   end

   // occupancy bitmap
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
      lx_ff <= lx_in; ly_ff <= ly_in; lz_ff <= lz_in;
      px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in;
      dx_ff <= dx_in; dy_ff <= dy_in; dz_ff <= dz_in;
      nx_ff <= nx_in; ny_ff <= ny_in; nz_ff <= nz_in;
      for (int i = 0; i < NUM_PROD; i++) prod_ff[i] <= prod_in[i];
      mcnt_ff    <= mcnt_in;
      steps_ff   <= steps_in;
      found_ff   <= found_in;
      limit_ff   <= limit_in;
      rd_data_ff <= rd_data_in;
   end

endmodule

FILE: test/voxel_ray_first_hit_core_tb.sv
// Testbench for the voxel ray first-hit core: directed and random beats against a predictor.
`timescale 1ns / 1ps

module voxel_ray_first_hit_core_tb;
   import vrfh_pkg::*;

   localparam int HALF      = 16;
   localparam int STEP_CAP  = 64;
   localparam int EDGE_Q    = 256;
   localparam int CYCLE_CAP = 3000000;
   localparam int HOLD_LEN  = 400;
   localparam int DRAIN_LEN = 2 * STEP_CAP + 40;

   // one request beat, unpacked
   typedef struct {
      logic              action;
      logic signed [15:0] sx, sy, sz, ex, ey, ez;
      logic signed [4:0]  cx, cy, cz;
      logic              occ;
   } req_beat_type;

   // one expected result beat
   typedef struct {
      logic       found;
      logic [4:0] hx, hy, hz;
      logic       limit;
   } hit_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   bit             occ_map [0:32767];
   hit_result_type pending_hits[$];
   int             fail_count = 0;
   int             cycle_count = 0;
   bit             idle_on = 1'b0;
   bit             hold_go = 1'b0;
   logic           hold_off = 1'b0;
   int             hold_cnt = 0;
   int             rx_stall_left = 0;

   voxel_ray_first_hit_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver: random stall bursts, plus the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off) begin
         rsp_tready <= 1'b0;
      end else if (rx_stall_left > 0) begin
         rx_stall_left <= rx_stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rx_stall_left <= $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // hold-off started once on request, its length counted here
   always @(posedge clock) begin
      if (hold_off) begin
         if (hold_cnt == HOLD_LEN) begin
            hold_off <= 1'b0;
         end else begin
            hold_cnt <= hold_cnt + 1;
         end
      end else if (hold_go && hold_cnt == 0) begin
         hold_off <= 1'b1;
      end
   end

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want, cycle_count);
      fail_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      hit_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_hits.size() == 0) begin
            report_mismatch("unexpected beat", int'(rsp_tdata), 0);
         end else begin
            want = pending_hits.pop_front();
            if (rsp_tdata[0] !== want.found)
               report_mismatch("hit_found", int'(rsp_tdata[0]), int'(want.found));
            if (rsp_tdata[5:1] !== want.hx)
               report_mismatch("hit_x", int'(rsp_tdata[5:1]), int'(want.hx));
            if (rsp_tdata[10:6] !== want.hy)
               report_mismatch("hit_y", int'(rsp_tdata[10:6]), int'(want.hy));
            if (rsp_tdata[15:11] !== want.hz)
               report_mismatch("hit_z", int'(rsp_tdata[15:11]), int'(want.hz));
            if (rsp_tdata[16] !== want.limit)
               report_mismatch("step_limit_hit", int'(rsp_tdata[16]), int'(want.limit));
         end
      end
   end

   function automatic int cell_addr(int x, int y, int z);
      return ((x + HALF) * 32 + (y + HALF)) * 32 + (z + HALF);
   endfunction

   function automatic bit in_grid(int x, int y, int z);
      return x >= -HALF && x < HALF && y >= -HALF && y < HALF && z >= -HALF && z < HALF;
   endfunction

   // exact boundary-time compare: axis a strictly before axis b
   function automatic bit crosses_first(longint num_a, longint den_a, longint num_b,
                                        longint den_b);
      if (den_a == 0) return 1'b0;
      if (den_b == 0) return 1'b1;
      return num_a * den_b < num_b * den_a;
   endfunction

   // apply one beat to the predicted grid and work out its result
   function automatic hit_result_type predict_hit(req_beat_type b);
      hit_result_type r;
      int vox[3], last[3], dir[3], s[3], e[3];
      longint num[3], den[3];
      int steps, pick;
      r = '{1'b0, 5'd0, 5'd0, 5'd0, 1'b0};
      if (b.action == ACT_WRITE) begin
         occ_map[cell_addr(b.cx, b.cy, b.cz)] = b.occ;
         return r;
      end
      s = '{int'(b.sx), int'(b.sy), int'(b.sz)};
      e = '{int'(b.ex), int'(b.ey), int'(b.ez)};
      for (int i = 0; i < 3; i++) begin
         vox[i]  = s[i] >>> 8;
         last[i] = e[i] >>> 8;
         dir[i]  = (e[i] >= s[i]) ? 1 : -1;
         den[i]  = (e[i] >= s[i]) ? e[i] - s[i] : s[i] - e[i];
         num[i]  = (dir[i] > 0) ? (vox[i] + 1) * EDGE_Q - s[i] : s[i] - vox[i] * EDGE_Q;
      end
      steps = 0;
      while (vox[0] != last[0] || vox[1] != last[1] || vox[2] != last[2]) begin
         if (steps >= STEP_CAP) begin
            r.limit = 1'b1;
            break;
         end
         // ties go to z, then y
         if (crosses_first(num[0], den[0], num[1], den[1]))
            pick = crosses_first(num[0], den[0], num[2], den[2]) ? 0 : 2;
         else
            pick = crosses_first(num[1], den[1], num[2], den[2]) ? 1 : 2;
         vox[pick] += dir[pick];
         num[pick] += EDGE_Q;
         steps++;
         if (!in_grid(vox[0], vox[1], vox[2])) break;
         if (occ_map[cell_addr(vox[0], vox[1], vox[2])]) begin
            r.found = 1'b1;
            r.hx = vox[0][4:0];
            r.hy = vox[1][4:0];
            r.hz = vox[2][4:0];
            break;
         end
      end
      return r;
   endfunction

   function automatic req_beat_type ray_beat(int sx, int sy, int sz, int ex, int ey, int ez);
      req_beat_type b;
      b = '{ACT_RAY, sx[15:0], sy[15:0], sz[15:0], ex[15:0], ey[15:0], ez[15:0],
            5'($urandom), 5'($urandom), 5'($urandom), 1'($urandom)};
      return b;
   endfunction

   function automatic req_beat_type write_beat(int x, int y, int z, bit occ);
      req_beat_type b;
      b = '{ACT_WRITE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
            16'($urandom), 16'($urandom), x[4:0], y[4:0], z[4:0], occ};
      return b;
   endfunction

   // send one beat, wait for acceptance, then predict
   task automatic send_beat(req_beat_type b);
      req_tvalid <= 1'b1;
      req_tuser  <= b.action;
      req_tdata  <= {b.occ, b.cz, b.cy, b.cx, b.ez, b.ey, b.ex, b.sz, b.sy, b.sx};
      do @(posedge clock); while (!req_tready);
      pending_hits.insert(pending_hits.size(), predict_hit(b));
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // Q8.8 coordinate somewhere in voxels [lo, hi]
   function automatic int q_in(int lo, int hi);
      return lo * EDGE_Q + int'($urandom_range(0, (hi - lo + 1) * EDGE_Q - 1));
   endfunction

   function automatic req_beat_type random_beat();
      int sel, sx, sy, sz;
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
         // most writes clustered near the center so that rays find hits
         if (sel < 22)
            return write_beat($urandom_range(0, 9) - 5, $urandom_range(0, 9) - 5,
                              $urandom_range(0, 9) - 5, $urandom_range(0, 2) != 0);
         return write_beat($urandom_range(0, 31) - 16, $urandom_range(0, 31) - 16,
                           $urandom_range(0, 31) - 16, 1'($urandom));
      end else if (sel < 90) begin
         sx = q_in(-10, 9); sy = q_in(-10, 9); sz = q_in(-10, 9);
         return ray_beat(sx, sy, sz, sx + q_in(-14, 13), sy + q_in(-14, 13),
                         sz + q_in(-14, 13));
      end else if (sel < 95) begin
         return ray_beat(q_in(-20, 19), q_in(-20, 19), q_in(-20, 19),
                         q_in(-20, 19), q_in(-20, 19), q_in(-20, 19));
      end
      return ray_beat($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endfunction

   task automatic test_directed();
      idle_on = 1'b1;
      send_beat(ray_beat(128, 128, 128, 200, 50, 255));               // one voxel, no step
      send_beat(ray_beat(-640, 128, 128, 640, 128, 128));             // hits origin
      send_beat(write_beat(0, 0, 0, 1'b0));
      send_beat(ray_beat(-640, 128, 128, 640, 128, 128));             // end voxel free
      send_beat(ray_beat(-3968, -3968, -2688, 3968, 3968, 2688));     // step limit
      send_beat(write_beat(0, 0, 0, 1'b1));
      send_beat(ray_beat(-128, -128, -128, 384, 384, 384));           // corner ties
      send_beat(ray_beat(3968, 128, 128, 5120, 128, 128));            // leaves the grid
      send_beat(ray_beat(-5120, 128, 128, 128, 128, 128));            // starts outside
      send_beat(write_beat(-16, -16, -16, 1'b1));
      send_beat(write_beat(15, 15, 15, 1'b1));
      send_beat(ray_beat(-3968, -3968, -3968, -4200, -4200, -4200));  // low corner
      send_beat(ray_beat(3700, 3700, 3700, 3900, 3900, 3900));        // high corner
      send_beat(ray_beat(32767, 32767, 32767, -32768, -32768, -32768));
      send_beat(ray_beat(-32768, -32768, -32768, 32767, 32767, 32767));
      send_beat(ray_beat(0, 0, 0, 0, 0, 0));                          // zero length
      send_beat(ray_beat(-1, -1, -1, 1, 1, 1));                       // hits origin
      send_beat(ray_beat(128, 128, 768, 128, 128, -768));             // z only, negative
      send_beat(write_beat(-16, 15, -16, 1'b0));
      send_beat(write_beat(15, -16, 15, 1'b0));
   endtask

   task automatic test_random_mix(int count);
      idle_on = 1'b1;
      repeat (count) send_beat(random_beat());
   endtask

   // receiver stalls long while the sender keeps offering beats
   task automatic test_output_backpressure();
      idle_on = 1'b0;
      hold_go = 1'b1;
      repeat (40) send_beat(random_beat());
   endtask

   task automatic test_full_rate(int count);
      idle_on = 1'b0;
      repeat (count) send_beat(random_beat());
   endtask

   initial begin
      for (int i = 0; i < 32768; i++) occ_map[i] = 1'b0;
      occ_map[cell_addr(0, 0, 0)] = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_mix(1500);
      test_output_backpressure();
      test_full_rate(450);
      req_tvalid <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_LEN) @(posedge clock);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
